### design/pdt_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the path distance tracker.
package pdt_pkg;

    localparam int KIND_W         = 2;
    localparam int COORD_W        = 32;
    localparam int MAG_W          = COORD_W + 1;
    localparam int SQ_W           = 2 * MAG_W;
    localparam int DIST_W         = 34;
    localparam int ROOT_REM_W     = DIST_W + 2;
    localparam int SUM_W          = 50;
    localparam int POINTS_W       = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int SQ_TERMS       = 4;
    localparam int SQ_CNT_W       = $clog2(SQ_TERMS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_LAUNCH,
        ST_ROOT,
        ST_SUM,
        ST_DIV_LAUNCH,
        ST_DIVIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic                      load_start;
        logic                      load_point;
        logic                      diff_en;
        logic                      sq_en;
        logic [$clog2(SQ_TERMS)-1:0] sq_sel;
        logic                      acc_en;
        logic                      acc_rad;
        logic                      sqrt_start;
        logic                      sum_en;
        logic                      div_start;
        logic                      load_out;
    } pdt_cmd_t;

    typedef struct packed {
        logic seg_done;
        logic rad_done;
        logic div_done;
    } pdt_status_t;

endpackage

### design/pdt_isqrt.sv
`timescale 1ns / 1ps
// Iterative floored square root, one result bit per cycle.
module pdt_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pdt_pkg::SQ_W-1:0]  radicand,
    output logic [pdt_pkg::DIST_W-1:0] root,
    output logic                      done
);
    import pdt_pkg::*;

    localparam int RAD_W = 2 * DIST_W;
    localparam int CNT_W = $clog2(DIST_W);

    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [ROOT_REM_W-1:0] rem_reg, rem_next;
    logic [DIST_W-1:0]     root_reg, root_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [ROOT_REM_W+1:0] rem_sh;
    logic [ROOT_REM_W+1:0] trial;
    logic [ROOT_REM_W+1:0] rem_diff;
    logic                  fits;

    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = (ROOT_REM_W + 2)'({root_reg, 2'b01});
        fits     = rem_sh >= trial;
        rem_diff = rem_sh - trial;

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(DIST_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? rem_diff[ROOT_REM_W-1:0] : rem_sh[ROOT_REM_W-1:0];
            root_next = {root_reg[DIST_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### design/pdt_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider for the mean distance, one quotient bit per cycle.
module pdt_divider #(
    parameter int DIVISOR_BITS = pdt_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pdt_pkg::SUM_W-1:0]  dividend,
    input  logic [DIVISOR_BITS-1:0]    divisor,
    output logic [pdt_pkg::SUM_W-1:0]  quotient,
    output logic                       done
);
    import pdt_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [DIVISOR_BITS:0]   rem_sh;
    logic [DIVISOR_BITS:0]   rem_diff;
    logic                    fits;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        fits     = rem_sh >= {1'b0, dvs_reg};
        rem_diff = rem_sh - {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(SUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### design/pdt_datapath.sv
`timescale 1ns / 1ps
// Datapath: point registers, squares, square roots, accumulators and result registers.
module pdt_datapath #(
    parameter int COUNT_BITS = pdt_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdt_pkg::pdt_cmd_t             cmd,
    output pdt_pkg::pdt_status_t          status,
    input  logic [pdt_pkg::COORD_W-1:0]   pos_x,
    input  logic [pdt_pkg::COORD_W-1:0]   pos_y,
    output logic [pdt_pkg::COORD_W-1:0]   end_x,
    output logic [pdt_pkg::COORD_W-1:0]   end_y,
    output logic [pdt_pkg::SUM_W-1:0]     path_length,
    output logic [pdt_pkg::DIST_W-1:0]    end_to_start,
    output logic [pdt_pkg::DIST_W-1:0]    mean_to_start,
    output logic [pdt_pkg::POINTS_W-1:0]  points_seen
);
    import pdt_pkg::*;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic [COORD_W-1:0]    origin_x_reg, origin_y_reg, last_x_reg, last_y_reg;
    logic [COORD_W-1:0]    pt_x_reg, pt_y_reg;
    logic [MAG_W-1:0]      mag_reg [SQ_TERMS];
    logic [SQ_W-1:0]       prod_reg;
    logic [SQ_W-1:0]       v_seg_reg, v_rad_reg;
    logic [SUM_W-1:0]      length_sum_reg, length_sum_next;
    logic [SUM_W-1:0]      radial_sum_reg, radial_sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [COORD_W-1:0]    end_x_reg, end_y_reg;
    logic [SUM_W-1:0]      path_length_reg;
    logic [DIST_W-1:0]     end_to_start_reg, mean_to_start_reg;
    logic [POINTS_W-1:0]   points_seen_reg;

    logic [MAG_W-1:0]      diff_val [SQ_TERMS];
    logic [MAG_W-1:0]      mag_val [SQ_TERMS];
    logic [MAG_W-1:0]      sq_op;
    logic [SQ_W-1:0]       sq_val;
    logic [DIST_W-1:0]     seg_root, rad_root;
    logic [SUM_W-1:0]      quotient;
    logic [SUM_W:0]        length_wide, radial_wide;

    always_comb
    begin
        diff_val[0] = {pt_x_reg[COORD_W-1], pt_x_reg} - {last_x_reg[COORD_W-1], last_x_reg};
        diff_val[1] = {pt_y_reg[COORD_W-1], pt_y_reg} - {last_y_reg[COORD_W-1], last_y_reg};
        diff_val[2] = {pt_x_reg[COORD_W-1], pt_x_reg}
                    - {origin_x_reg[COORD_W-1], origin_x_reg};
        diff_val[3] = {pt_y_reg[COORD_W-1], pt_y_reg}
                    - {origin_y_reg[COORD_W-1], origin_y_reg};
        for (int i = 0; i < SQ_TERMS; i++)
        begin
            mag_val[i] = diff_val[i][MAG_W-1] ? (~diff_val[i] + 1'b1) : diff_val[i];
        end
        sq_op  = mag_reg[cmd.sq_sel];
        sq_val = SQ_W'(sq_op) * SQ_W'(sq_op);

        length_wide = {1'b0, length_sum_reg} + (SUM_W + 1)'(seg_root);
        radial_wide = {1'b0, radial_sum_reg} + (SUM_W + 1)'(rad_root);
        length_sum_next = length_wide[SUM_W] ? SUM_MAX : length_wide[SUM_W-1:0];
        radial_sum_next = radial_wide[SUM_W] ? SUM_MAX : radial_wide[SUM_W-1:0];
        count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            length_sum_reg <= '0;
            radial_sum_reg <= '0;
            count_reg      <= '0;
        end
        else if (cmd.load_start)
        begin
            origin_x_reg   <= pos_x;
            origin_y_reg   <= pos_y;
            last_x_reg     <= pos_x;
            last_y_reg     <= pos_y;
            length_sum_reg <= '0;
            radial_sum_reg <= '0;
            count_reg      <= '0;
        end
        else if (cmd.sum_en)
        begin
            last_x_reg     <= pt_x_reg;
            last_y_reg     <= pt_y_reg;
            length_sum_reg <= length_sum_next;
            radial_sum_reg <= radial_sum_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            pt_x_reg <= pos_x;
            pt_y_reg <= pos_y;
        end
        if (cmd.diff_en)
        begin
            for (int i = 0; i < SQ_TERMS; i++)
            begin
                mag_reg[i] <= mag_val[i];
            end
            v_seg_reg <= '0;
            v_rad_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (cmd.acc_rad)
            begin
                v_rad_reg <= v_rad_reg + prod_reg;
            end
            else
            begin
                v_seg_reg <= v_seg_reg + prod_reg;
            end
        end
        if (cmd.sq_en)
        begin
            prod_reg <= sq_val;
        end
        if (cmd.load_out)
        begin
            end_x_reg         <= pt_x_reg;
            end_y_reg         <= pt_y_reg;
            path_length_reg   <= length_sum_reg;
            end_to_start_reg  <= rad_root;
            mean_to_start_reg <= (count_reg == '0) ? '0 : quotient[DIST_W-1:0];
            points_seen_reg   <= POINTS_W'(count_reg);
        end
    end

    pdt_isqrt u_seg_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (v_seg_reg),
        .root     (seg_root),
        .done     (status.seg_done)
    );

    pdt_isqrt u_rad_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (v_rad_reg),
        .root     (rad_root),
        .done     (status.rad_done)
    );

    pdt_divider #(
        .DIVISOR_BITS (COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (radial_sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (status.div_done)
    );

    assign end_x         = end_x_reg;
    assign end_y         = end_y_reg;
    assign path_length   = path_length_reg;
    assign end_to_start  = end_to_start_reg;
    assign mean_to_start = mean_to_start_reg;
    assign points_seen   = points_seen_reg;

endmodule

### design/pdt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: record decode, sequencing of the datapath, result handshake.
module pdt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pdt_pkg::KIND_W-1:0]  kind,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pdt_pkg::pdt_cmd_t           cmd,
    input  pdt_pkg::pdt_status_t        status
);
    import pdt_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic                started_reg, started_next;
    logic                stop_reg, stop_next;
    logic                out_valid_reg, out_valid_next;
    logic [SQ_CNT_W-1:0] cnt_reg, cnt_next;

    logic                take_start;
    logic                take_point;
    logic                out_free;

    always_comb
    begin
        take_start = in_valid && (kind == KIND_START);
        take_point = in_valid && started_reg && (kind inside {KIND_DATA, KIND_STOP});
        out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_point)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:       state_next = ST_SQUARE;
            ST_SQUARE:
            begin
                if (cnt_reg == SQ_CNT_W'(SQ_TERMS))
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:     state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (status.seg_done && status.rad_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:        state_next = stop_reg ? ST_DIV_LAUNCH : ST_IDLE;
            ST_DIV_LAUNCH: state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        started_next   = started_reg;
        stop_next      = stop_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (take_start)
                begin
                    cmd.load_start = 1'b1;
                    started_next   = 1'b1;
                end
                else if (take_point)
                begin
                    cmd.load_point = 1'b1;
                    stop_next      = (kind == KIND_STOP);
                end
            end
            ST_DIFF:
            begin
                cmd.diff_en = 1'b1;
                cnt_next    = '0;
            end
            ST_SQUARE:
            begin
                cmd.sq_en   = (cnt_reg != SQ_CNT_W'(SQ_TERMS));
                cmd.sq_sel  = cnt_reg[$clog2(SQ_TERMS)-1:0];
                cmd.acc_en  = (cnt_reg != '0);
                cmd.acc_rad = (cnt_reg > SQ_CNT_W'(SQ_TERMS / 2));
                cnt_next    = cnt_reg + 1'b1;
            end
            ST_LAUNCH:     cmd.sqrt_start = 1'b1;
            ST_SUM:        cmd.sum_en = 1'b1;
            ST_DIV_LAUNCH: cmd.div_start = 1'b1;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    started_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/path_distance_tracker_core.sv
`timescale 1ns / 1ps
// Top level of the path distance tracker: controller and datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  request  | in_valid / in_ready  | kind, pos_x, pos_y
//  result   | out_valid / out_ready| end_x, end_y, path_length, end_to_start,
//           |                      | mean_to_start, points_seen
//
// A START or an ignored record is taken in IDLE with no further work. A DATA point goes through decode,
// differences, four squares through one 33x33 multiplier, then two 34-step square roots
// running side by side. A STOP point adds the 50-step mean divider.
// Reset clears the control state and the accumulators; no clearing pass is needed.
// The result register lets a new request in while a result waits; a stalled result
// holds the block only when the next result is ready to be loaded.
module path_distance_tracker_core #(
    parameter int COUNT_BITS = pdt_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pdt_pkg::KIND_W-1:0]    kind,
    input  logic [pdt_pkg::COORD_W-1:0]   pos_x,
    input  logic [pdt_pkg::COORD_W-1:0]   pos_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pdt_pkg::COORD_W-1:0]   end_x,
    output logic [pdt_pkg::COORD_W-1:0]   end_y,
    output logic [pdt_pkg::SUM_W-1:0]     path_length,
    output logic [pdt_pkg::DIST_W-1:0]    end_to_start,
    output logic [pdt_pkg::DIST_W-1:0]    mean_to_start,
    output logic [pdt_pkg::POINTS_W-1:0]  points_seen
);
    import pdt_pkg::*;

    pdt_cmd_t    cmd;
    pdt_status_t status;

    pdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pdt_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .path_length   (path_length),
        .end_to_start  (end_to_start),
        .mean_to_start (mean_to_start),
        .points_seen   (points_seen)
    );

    a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_point |=> !in_ready)
        else $error("request taken while a point is in work");

    a_roots_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        status.seg_done == status.rad_done)
        else $error("square root units out of step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("pending result overwritten");

endmodule

### tb/path_distance_tracker_checker.sv
`timescale 1ns / 1ps
// Checker for the path distance tracker: predicts each path summary and compares results.
module path_distance_tracker_checker
    import pdt_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [COORD_W-1:0]  pos_x,
    input  logic [COORD_W-1:0]  pos_y,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [COORD_W-1:0]  end_x,
    input  logic [COORD_W-1:0]  end_y,
    input  logic [SUM_W-1:0]    path_length,
    input  logic [DIST_W-1:0]   end_to_start,
    input  logic [DIST_W-1:0]   mean_to_start,
    input  logic [POINTS_W-1:0] points_seen,
    output int                  fail_count,
    output int                  pending
);

    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam longint unsigned  COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int               MAX_PRINTS = 50;

    typedef struct packed {
        logic [COORD_W-1:0]  end_x;
        logic [COORD_W-1:0]  end_y;
        logic [SUM_W-1:0]    path_length;
        logic [DIST_W-1:0]   end_to_start;
        logic [DIST_W-1:0]   mean_to_start;
        logic [POINTS_W-1:0] points_seen;
    } path_summary_t;

    logic               tracking;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    logic [SUM_W-1:0]   length_acc;
    logic [SUM_W-1:0]   radial_acc;
    longint unsigned    point_cnt;
    path_summary_t      summaries_due[$];
    path_summary_t      oldest;

    function automatic logic [DIST_W-1:0] floor_dist(input logic [COORD_W-1:0] ax,
                                                     input logic [COORD_W-1:0] ay,
                                                     input logic [COORD_W-1:0] bx,
                                                     input logic [COORD_W-1:0] by);
        logic signed [MAG_W-1:0] dx;
        logic signed [MAG_W-1:0] dy;
        logic [MAG_W-1:0]        abs_x;
        logic [MAG_W-1:0]        abs_y;
        logic [2*DIST_W-1:0]     mag_x;
        logic [2*DIST_W-1:0]     mag_y;
        logic [2*DIST_W-1:0]     radicand;
        logic [2*DIST_W-1:0]     trial;
        logic [DIST_W-1:0]       root;
        int                      bit_idx;
        dx = $signed({ax[COORD_W-1], ax}) - $signed({bx[COORD_W-1], bx});
        dy = $signed({ay[COORD_W-1], ay}) - $signed({by[COORD_W-1], by});
        abs_x = dx[MAG_W-1] ? -dx : dx;
        abs_y = dy[MAG_W-1] ? -dy : dy;
        mag_x = abs_x;
        mag_y = abs_y;
        radicand = mag_x * mag_x + mag_y * mag_y;
        root = '0;
        for (bit_idx = DIST_W - 1; bit_idx >= 0; bit_idx--)
        begin
            trial = root | ((2*DIST_W)'(1) << bit_idx);
            if (trial * trial <= radicand)
            begin
                root = trial[DIST_W-1:0];
            end
        end
        return root;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  acc,
                                                 input logic [DIST_W-1:0] step);
        logic [SUM_W:0] total;
        total = acc + step;
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    task automatic track_point(input logic [KIND_W-1:0]  k,
                               input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y);
        logic [DIST_W-1:0] seg;
        logic [DIST_W-1:0] rad;
        path_summary_t     summary;
        if (k == KIND_START)
        begin
            tracking   = 1'b1;
            origin_x   = x;
            origin_y   = y;
            last_x     = x;
            last_y     = y;
            length_acc = '0;
            radial_acc = '0;
            point_cnt  = 0;
        end
        else if (tracking && (k == KIND_DATA || k == KIND_STOP))
        begin
            seg = floor_dist(x, y, last_x, last_y);
            rad = floor_dist(x, y, origin_x, origin_y);
            length_acc = sat_add(length_acc, seg);
            radial_acc = sat_add(radial_acc, rad);
            if (point_cnt < COUNT_MAX)
            begin
                point_cnt++;
            end
            last_x = x;
            last_y = y;
            if (k == KIND_STOP)
            begin
                summary.end_x         = x;
                summary.end_y         = y;
                summary.path_length   = length_acc;
                summary.end_to_start  = rad;
                summary.mean_to_start = DIST_W'(radial_acc / point_cnt);
                summary.points_seen   = POINTS_W'(point_cnt);
                summaries_due.push_back(summary);
                tracking = 1'b0;
            end
        end
    endtask

    task automatic report_error(input string msg);
        if (fail_count < MAX_PRINTS)
        begin
            $display("%0t ERROR: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s is %h, predicted %h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking   = 1'b0;
            origin_x   = '0;
            origin_y   = '0;
            last_x     = '0;
            last_y     = '0;
            length_acc = '0;
            radial_acc = '0;
            point_cnt  = 0;
            summaries_due.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (summaries_due.size() == 0)
                begin
                    report_error("result with no summary pending");
                end
                else
                begin
                    oldest = summaries_due.pop_front();
                    check_field("end_x", end_x, oldest.end_x);
                    check_field("end_y", end_y, oldest.end_y);
                    check_field("path_length", path_length, oldest.path_length);
                    check_field("end_to_start", end_to_start, oldest.end_to_start);
                    check_field("mean_to_start", mean_to_start, oldest.mean_to_start);
                    check_field("points_seen", points_seen, oldest.points_seen);
                end
            end
            if (in_valid && in_ready)
            begin
                track_point(kind, pos_x, pos_y);
            end
            pending = summaries_due.size();
        end
    end

endmodule

### tb/path_distance_tracker_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the path distance tracker: stimulus, flow control and verdict.
module path_distance_tracker_core_tb;
    import pdt_pkg::*;

    localparam logic [KIND_W-1:0]  KIND_UNUSED  = 2'd3;
    localparam logic [COORD_W-1:0] COORD_MAX    = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] COORD_MIN    = 32'h8000_0000;
    localparam int                 ITEMS_TARGET = 1650;
    localparam int                 IDLE_LIMIT   = 5000;
    localparam int                 DRAIN_CYCLES = 150;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KIND_W-1:0]   kind;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic                out_valid;
    logic                out_ready;
    logic [COORD_W-1:0]  end_x;
    logic [COORD_W-1:0]  end_y;
    logic [SUM_W-1:0]    path_length;
    logic [DIST_W-1:0]   end_to_start;
    logic [DIST_W-1:0]   mean_to_start;
    logic [POINTS_W-1:0] points_seen;
    int                  fail_count;
    int                  pending;
    int                  burst_left;
    int                  idle_cycles;

    path_distance_tracker_core u_top (.*);

    path_distance_tracker_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input logic [KIND_W-1:0]  k,
                                input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind     <= k;
        pos_x    <= x;
        pos_y    <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] near);
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3, 4:    return near + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            5:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000;
        endcase
    endfunction

    // receiver flow control
    initial
    begin
        int stall_mode;
        int stall_tick;
        out_ready = 1'b0;
        stall_tick = 0;
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            repeat ($urandom_range(100, 400))
            begin
                @(negedge clk);
                stall_tick++;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ((stall_tick % 128) >= 90);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** path_distance_tracker_core: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        int                 n_points;
        int                 seq_items;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_DATA;
        pos_x      = '0;
        pos_y      = '0;
        burst_left = 0;
        x          = '0;
        y          = '0;
        seq_items  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // records before any start point, and the unused tag
        send_request(KIND_DATA, COORD_MAX, COORD_MIN);
        send_request(KIND_STOP, COORD_MIN, COORD_MAX);
        send_request(KIND_UNUSED, '0, '1);
        // corner to corner, the longest segments
        send_request(KIND_START, COORD_MIN, COORD_MIN);
        send_request(KIND_DATA, COORD_MAX, COORD_MAX);
        send_request(KIND_UNUSED, 32'h1234_5678, 32'h9abc_def0);
        send_request(KIND_DATA, COORD_MIN, COORD_MAX);
        send_request(KIND_STOP, COORD_MAX, COORD_MIN);
        // stop right on the start point
        send_request(KIND_START, '0, '0);
        send_request(KIND_STOP, '0, '0);
        // restart drops the partial path
        send_request(KIND_START, 32'h0001_0000, 32'h0002_0000);
        send_request(KIND_DATA, 32'h0005_0000, 32'hffff_0000);
        send_request(KIND_START, 32'hfff9_0000, 32'h0003_0000);
        send_request(KIND_DATA, 32'hfff9_0001, 32'h0003_0001);
        send_request(KIND_DATA, 32'h0000_0003, 32'h0000_0004);
        send_request(KIND_STOP, '1, '1);
        // stop while waiting is dropped
        send_request(KIND_STOP, COORD_MAX, COORD_MAX);
        send_request(KIND_START, COORD_MAX, '0);
        send_request(KIND_DATA, COORD_MIN, '0);
        send_request(KIND_DATA, COORD_MAX, COORD_MIN);
        send_request(KIND_STOP, COORD_MIN, COORD_MAX);

        while (seq_items < ITEMS_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(KIND_W'($urandom_range(0, 3)), $urandom, $urandom);
            end
            else
            begin
                x = pick_coord(x);
                y = pick_coord(y);
                send_request(KIND_START, x, y);
                n_points = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 5);
                repeat (n_points)
                begin
                    x = pick_coord(x);
                    y = pick_coord(y);
                    if ($urandom_range(0, 39) == 0)
                    begin
                        send_request(KIND_UNUSED, $urandom, $urandom);
                    end
                    if ($urandom_range(0, 49) == 0)
                    begin
                        send_request(KIND_START, x, y);
                    end
                    else
                    begin
                        send_request(KIND_DATA, x, y);
                    end
                end
                x = pick_coord(x);
                y = pick_coord(y);
                if ($urandom_range(0, 19) != 0)
                begin
                    send_request(KIND_STOP, x, y);
                end
                seq_items += n_points + 2;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** path_distance_tracker_core: PASSED **");
        end
        else
        begin
            $display("** path_distance_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule
